// File: rtl/core/vfpq_pkg.sv
`timescale 1ns / 1ps

package vfpq_pkg;

   localparam int PTS_W      = 48;
   localparam int HANDLE_W   = 16;
   localparam int CFG_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] START_FILL_RESET  = 5'd5;
   localparam logic [CFG_W-1:0] READY_LIMIT_RESET = 5'd10;

   // register index, taken from paddr[2]
   localparam logic [0:0] CSR_START_FILL  = 1'b0;
   localparam logic [0:0] CSR_READY_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_PLAY  = 2'd2,
      CMD_PAUSE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_BUFFERING = 2'd1,
      MODE_PLAYING   = 2'd2,
      MODE_PAUSED    = 2'd3
   } mode_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [PTS_W-1:0]    frame_pts;
      logic [HANDLE_W-1:0] frame_handle;
      logic [PTS_W-1:0]    now_time;
      logic                source_ended;
   } req_type;

   typedef struct packed {
      logic                shown_valid;
      logic [HANDLE_W-1:0] shown_handle;
      logic [PTS_W-1:0]    shown_pts;
      logic [CFG_W-1:0]    fill_count;
      logic                accept_ready;
      logic [1:0]          play_mode;
      logic                resume_request;
      logic                suspend_request;
      logic                push_dropped;
   } rsp_type;

   typedef struct packed {
      logic [PTS_W-1:0]    pts;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic [CFG_W-1:0] start_fill;
      logic [CFG_W-1:0] ready_limit;
   } cfg_type;

endpackage

// File: rtl/core/vfpq_store.sv
`timescale 1ns / 1ps

// Frame store: one write port, one read port, registered read data.
module vfpq_store
   import vfpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   input  entry_type                      wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   output entry_type                      rd_data
);

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/vfpq_ctrl.sv
`timescale 1ns / 1ps

// Queue sequencer: FIFO pointers, playback mode, head drop and minimum scan.
module vfpq_ctrl
   import vfpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  req_type                        req_data,
   input  logic                           out_free,
   output logic                           res_valid,
   output rsp_type                        res_data,
   output logic                           wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   output entry_type                      wr_data,
   output logic                           rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   input  entry_type                      rd_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DROP = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   mode_type         mode_ff, mode_in;
   logic [PTS_W-1:0] start_time_ff, start_time_in;
   logic             susp_ff, susp_in;
   logic [PTS_W-1:0] elapsed_ff, elapsed_in;
   logic             started_ff, started_in;
   logic             resume_ff, resume_in;
   entry_type        best_ff, best_in;
   logic [IDX_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0] scan_left_ff, scan_left_in;
   logic             pend_ff, pend_in;

   logic [SUM_W-1:0] tail_sum;
   logic [IDX_W-1:0] tail_idx;
   logic [IDX_W-1:0] head_next;
   logic [IDX_W-1:0] scan_next;
   logic [PTS_W:0]   time_diff;
   logic             latch_start;
   logic [CMP_W-1:0] fill_ext;
   logic             shown_valid;
   entry_type        shown_entry;
   logic             dropped;
   logic             suspend;
   logic             resume_out;

   assign req_ready = (state_ff == ST_IDLE) && out_free;

   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx  = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM) : IDX_W'(tail_sum);
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign scan_next = (scan_addr_ff == LAST_IDX) ? '0 : scan_addr_ff + 1'b1;

   // borrow out of the subtract means the clock has not reached the start time
   assign time_diff   = {1'b0, req_data.now_time} - {1'b0, start_time_ff};
   assign latch_start = (mode_ff == MODE_BUFFERING) && (count_ff != '0) &&
                        ((CMP_W'(count_ff) >= CMP_W'(cfg.start_fill)) || req_data.source_ended);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      start_time_in = start_time_ff;
      susp_in       = susp_ff;
      elapsed_in    = elapsed_ff;
      started_in    = started_ff;
      resume_in     = resume_ff;
      best_in       = best_ff;
      scan_addr_in  = scan_addr_ff;
      scan_left_in  = scan_left_ff;
      pend_in       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = tail_idx;
      wr_data       = '{pts: req_data.frame_pts, handle: req_data.frame_handle};
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      res_valid     = 1'b0;
      shown_valid   = 1'b0;
      shown_entry   = '0;
      dropped       = 1'b0;
      suspend       = 1'b0;
      resume_out    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (req_data.cmd)
                  CMD_PUSH: begin
                     res_valid = 1'b1;
                     if (count_ff == DEPTH_CNT) begin
                        dropped = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_PLAY: begin
                     res_valid = 1'b1;
                     mode_in   = MODE_BUFFERING;
                  end
                  CMD_PAUSE: begin
                     res_valid = 1'b1;
                     if (mode_ff == MODE_PLAYING) begin
                        suspend = 1'b1;
                        susp_in = 1'b1;
                        mode_in = MODE_PAUSED;
                     end
                  end
                  CMD_QUERY: begin
                     if ((count_ff != '0) && ((mode_ff == MODE_PLAYING) || latch_start)) begin
                        if (latch_start) begin
                           start_time_in = req_data.now_time;
                           mode_in       = MODE_PLAYING;
                        end
                        elapsed_in = latch_start ? '0 : time_diff[PTS_W-1:0];
                        started_in = latch_start || !time_diff[PTS_W];
                        resume_in  = 1'b0;
                        rd_en      = 1'b1;
                        rd_addr    = head_ff;
                        state_in   = ST_DROP;
                     end else begin
                        res_valid = 1'b1;
                     end
                  end
                  default: begin
                     res_valid = 1'b1;
                  end
               endcase
            end
         end
         ST_DROP: begin
            // head entry is on rd_data; drop it if elapsed, keeping one
            if (started_ff && (count_ff > CNT_W'(1)) && (rd_data.pts <= elapsed_ff)) begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               if (susp_ff) begin
                  susp_in   = 1'b0;
                  resume_in = 1'b1;
               end
               rd_en   = 1'b1;
               rd_addr = head_next;
            end else begin
               best_in      = rd_data;
               scan_addr_in = head_next;
               scan_left_in = count_ff - 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // strict compare: on equal timestamps the earlier slot stays
            if (pend_ff && (rd_data.pts < best_ff.pts)) begin
               best_in = rd_data;
            end
            if (scan_left_ff != '0) begin
               rd_en        = 1'b1;
               rd_addr      = scan_addr_ff;
               scan_addr_in = scan_next;
               scan_left_in = scan_left_ff - 1'b1;
               pend_in      = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               res_valid   = 1'b1;
               shown_valid = 1'b1;
               shown_entry = best_ff;
               resume_out  = resume_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      fill_ext                 = CMP_W'(count_in);
      res_data.shown_valid     = shown_valid;
      res_data.shown_handle    = shown_entry.handle;
      res_data.shown_pts       = shown_entry.pts;
      res_data.fill_count      = fill_ext[CFG_W-1:0];
      res_data.accept_ready    = fill_ext < CMP_W'(cfg.ready_limit);
      res_data.play_mode       = mode_in;
      res_data.resume_request  = resume_out;
      res_data.suspend_request = suspend;
      res_data.push_dropped    = dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         mode_ff       <= MODE_IDLE;
         start_time_ff <= '0;
         susp_ff       <= 1'b0;
         resume_ff     <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         mode_ff       <= mode_in;
         start_time_ff <= start_time_in;
         susp_ff       <= susp_in;
         resume_ff     <= resume_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff   <= elapsed_in;
      started_ff   <= started_in;
      best_ff      <= best_in;
      scan_addr_ff <= scan_addr_in;
      scan_left_ff <= scan_left_in;
   end

endmodule

// File: rtl/core/video_frame_presentation_queue.sv
`timescale 1ns / 1ps

// Presentation queue for decoded frames (timestamp plus buffer handle) with a
// playback mode of idle, buffering, playing or paused. Every request gives
// exactly one response. Push, play and pause complete in the cycle they are
// accepted; the response sits in the output register the next cycle. A query
// that returns no frame is equally quick. A query that returns a frame takes
// longer, because the frame store has a single read port: elapsed head
// frames are retired one a cycle, then the remaining frames are read one a
// cycle to find the earliest timestamp. One request is in the sequencer at a
// time; a new request is taken only when the sequencer is idle and the
// response register is empty or is being read in the same cycle. start_fill
// and ready_limit live at byte addresses 0 and 4 of the csr_ port and should
// be written only while idle.
module video_frame_presentation_queue
   import vfpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   // ---- configuration registers ----
   logic [CFG_W-1:0] start_fill_ff, start_fill_in;
   logic [CFG_W-1:0] ready_limit_ff, ready_limit_in;
   logic             csr_write;
   logic [0:0]       csr_index;
   cfg_type          cfg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      start_fill_in  = start_fill_ff;
      ready_limit_in = ready_limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_START_FILL:  start_fill_in  = csr_pwdata[CFG_W-1:0];
            CSR_READY_LIMIT: ready_limit_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_START_FILL:  csr_prdata = CSR_DATA_W'(start_fill_ff);
         CSR_READY_LIMIT: csr_prdata = CSR_DATA_W'(ready_limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_fill_ff  <= START_FILL_RESET;
         ready_limit_ff <= READY_LIMIT_RESET;
      end else begin
         start_fill_ff  <= start_fill_in;
         ready_limit_ff <= ready_limit_in;
      end
   end

   assign cfg = '{start_fill: start_fill_ff, ready_limit: ready_limit_ff};

   // ---- sequencer and frame store ----
   logic             out_free;
   logic             res_valid;
   rsp_type          res_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   vfpq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   vfpq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---- response register ----
   // free when empty or being taken this cycle
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- checks ----
   // non-query requests answer straight away
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.cmd != CMD_QUERY)) |=> rsp_valid)
   else $error("push/play/pause response not registered");

   // no frame shown means zeroed frame fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.shown_valid) |->
         ((rsp_data.shown_pts == '0) && (rsp_data.shown_handle == '0)))
   else $error("frame fields set without a shown frame");

   // a suspend only comes with entry to paused
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.suspend_request) |->
         ((rsp_data.play_mode == MODE_PAUSED) && !rsp_data.shown_valid))
   else $error("suspend outside pause");

   // frames are only shown while playing, and resume only accompanies a shown frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.shown_valid || rsp_data.resume_request)) |->
         ((rsp_data.play_mode == MODE_PLAYING) && rsp_data.shown_valid))
   else $error("frame or resume outside playing");

endmodule
